### rtl/bvcp_pkg.sv
// ----------------------------------------------------------------------------
// bvcp_pkg
// Shared types and constants for the battery voltage to charge percent unit:
// field widths, breakpoint table types, register indexes and the data that
// moves from one pipeline cell to the next.
// ----------------------------------------------------------------------------
package bvcp_pkg;

    // Field widths
    localparam int MV_W       = 13;
    localparam int CHG_W      = 7;
    localparam int VOLT_W     = 16;
    localparam int PCT_W      = 8;
    localparam int MAX_POINTS = 10;

    // Divider shape: quotient never exceeds one percent byte
    localparam int QUO_W = PCT_W;
    localparam int REM_W = VOLT_W + PCT_W;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [PCT_W-1:0] FULL_PERCENT = PCT_W'(100);

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VOLT_0_3 = 3'd0,
        CFG_VOLT_4_7 = 3'd1,
        CFG_VOLT_8_9 = 3'd2,
        CFG_PCT_0_7  = 3'd3,
        CFG_PCT_8_9  = 3'd4
    } cfg_reg_t;

    // Default breakpoint table
    localparam logic [63:0] VOLT_0_3_RST = 64'h0E8C_0E6C_0DF4_0C84;
    localparam logic [63:0] VOLT_4_7_RST = 64'h0F34_0EE4_0EC4_0EAC;
    localparam logic [31:0] VOLT_8_9_RST = 32'h1024_0F8C;
    localparam logic [63:0] PCT_0_7_RST  = 64'h4537_291C_130B_0500;
    localparam logic [15:0] PCT_8_9_RST  = 16'h6454;

    typedef logic [MAX_POINTS-1:0][VOLT_W-1:0] volt_tab_t;
    typedef logic [MAX_POINTS-1:0][PCT_W-1:0]  pct_tab_t;

    // Output of the segment select cell
    typedef struct packed {
        logic              fixed;    // result is base, no interpolation
        logic              falling;  // percent drops across the segment
        logic [PCT_W-1:0]  base;
        logic [VOLT_W-1:0] width;
        logic [VOLT_W-1:0] offset;
        logic [PCT_W-1:0]  diff;
        logic [VOLT_W-1:0] bias;     // width - 1 when falling, else zero, for ceiling division
    } seg_data_t;

    // Data handed along the divider cells
    typedef struct packed {
        logic              fixed;
        logic              falling;
        logic [PCT_W-1:0]  base;
        logic [VOLT_W-1:0] width;
        logic [REM_W-1:0]  rem;
        logic [QUO_W-1:0]  quo;
    } div_data_t;

endpackage

### rtl/bvcp_seg.sv
// ----------------------------------------------------------------------------
// bvcp_seg
// First cell: compares the voltage against every breakpoint, picks the
// segment and forms the operands of the interpolation.
// ----------------------------------------------------------------------------
module bvcp_seg
    import bvcp_pkg::*;
#(
    parameter int POINT_COUNT = 10
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [MV_W-1:0]   battery_mv,
    input  volt_tab_t         volts,
    input  pct_tab_t          pcts,
    output logic              out_valid,
    input  logic              out_ready,
    output seg_data_t         out_data
);

    localparam int LAST = POINT_COUNT - 1;

    logic      valid_reg;
    seg_data_t data_reg;
    seg_data_t data_next;

    // Find the segment and build the operands
    always_comb
    begin
        logic [VOLT_W-1:0] v16;
        logic [VOLT_W-1:0] vl;
        logic [VOLT_W-1:0] vh;
        logic [PCT_W-1:0]  pl;
        logic [PCT_W-1:0]  ph;
        logic              found;
        v16   = {{(VOLT_W-MV_W){1'b0}}, battery_mv};
        vl    = volts[LAST-1];
        vh    = volts[LAST];
        pl    = pcts[LAST-1];
        ph    = pcts[LAST];
        found = 1'b0;
        for (int i = 0; i < LAST; i++)
        begin
            if (!found && (v16 < volts[i+1]))
            begin
                vl    = volts[i];
                vh    = volts[i+1];
                pl    = pcts[i];
                ph    = pcts[i+1];
                found = 1'b1;
            end
        end

        data_next.falling = (ph < pl);
        data_next.diff    = (ph < pl) ? (pl - ph) : (ph - pl);
        data_next.width   = vh - vl;
        data_next.offset  = v16 - vl;
        data_next.bias    = (ph < pl) ? (vh - vl - VOLT_W'(1)) : '0;
        data_next.fixed   = 1'b1;
        data_next.base    = pl;

        if (v16 <= volts[0])
        begin
            data_next.base = pcts[0];
        end
        else if (v16 >= volts[LAST])
        begin
            data_next.base = FULL_PERCENT;
        end
        else if ((vh <= vl) || (v16 < vl))
        begin
            data_next.base = pl;
        end
        else
        begin
            data_next.fixed = 1'b0;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    // Advance the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Capture the item
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/bvcp_mul.sv
// ----------------------------------------------------------------------------
// bvcp_mul
// Second cell: multiplies the voltage offset by the percent span and adds
// the rounding bias, giving the dividend for the divider cells.
// ----------------------------------------------------------------------------
module bvcp_mul
    import bvcp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  seg_data_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output div_data_t out_data
);

    logic      valid_reg;
    div_data_t data_reg;
    div_data_t data_next;

    // Form the dividend
    always_comb
    begin
        logic [REM_W-1:0] prod;
        prod = {{PCT_W{1'b0}}, in_data.offset} * {{VOLT_W{1'b0}}, in_data.diff};
        data_next.fixed   = in_data.fixed;
        data_next.falling = in_data.falling;
        data_next.base    = in_data.base;
        data_next.width   = in_data.width;
        data_next.rem     = prod + {{PCT_W{1'b0}}, in_data.bias};
        data_next.quo     = '0;
    end

    assign in_ready = !valid_reg || out_ready;

    // Advance the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Capture the item
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/bvcp_div_cell.sv
// ----------------------------------------------------------------------------
// bvcp_div_cell
// One restoring division cell: settles one quotient bit by comparing the
// partial remainder against the shifted segment width.
// ----------------------------------------------------------------------------
module bvcp_div_cell
    import bvcp_pkg::*;
#(
    parameter int BIT = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  div_data_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output div_data_t out_data
);

    logic      valid_reg;
    div_data_t data_reg;
    div_data_t data_next;

    // Trial subtract of the shifted divisor
    always_comb
    begin
        logic [REM_W-1:0] dvs;
        dvs       = {{PCT_W{1'b0}}, in_data.width} << BIT;
        data_next = in_data;
        if (in_data.rem >= dvs)
        begin
            data_next.rem      = in_data.rem - dvs;
            data_next.quo[BIT] = 1'b1;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    // Advance the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Capture the item
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/bvcp_finish.sv
// ----------------------------------------------------------------------------
// bvcp_finish
// Last cell: applies the quotient to the base percent unless the result is
// fixed, saturates at full charge and holds the result for the output channel.
// ----------------------------------------------------------------------------
module bvcp_finish
    import bvcp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  div_data_t        in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [CHG_W-1:0] charge_percent
);

    logic             valid_reg;
    logic [CHG_W-1:0] charge_reg;
    logic [CHG_W-1:0] charge_next;

    // Combine and saturate
    always_comb
    begin
        logic [PCT_W:0] sum;
        if (in_data.fixed)
        begin
            sum = {1'b0, in_data.base};
        end
        else if (in_data.falling)
        begin
            sum = {1'b0, in_data.base} - {1'b0, in_data.quo};
        end
        else
        begin
            sum = {1'b0, in_data.base} + {1'b0, in_data.quo};
        end
        if (sum > {1'b0, FULL_PERCENT})
        begin
            sum = {1'b0, FULL_PERCENT};
        end
        charge_next = sum[CHG_W-1:0];
    end

    assign in_ready = !valid_reg || out_ready;

    // Advance the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Hold the result
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            charge_reg <= charge_next;
        end
    end

    assign out_valid      = valid_reg;
    assign charge_percent = charge_reg;

endmodule

### rtl/battery_voltage_to_charge_percent_unit.sv
// ----------------------------------------------------------------------------
// battery_voltage_to_charge_percent_unit
// Converts a battery voltage in millivolts to a charge percent by linear
// interpolation over a ten-point breakpoint table held in registers.
//
//   channel  direction  handshake              payload
//   in       in         in_valid / in_ready    battery_mv (13 bit)
//   out      out        out_valid / out_ready  charge_percent (7 bit)
//   cfg      in         cfg_valid / cfg_ready  cfg_index (3 bit), cfg_data (64 bit)
//
// One item per clock while out is not stalled. Cells in order: segment select,
// multiply, the 8 divider cells with one quotient bit each, and the output cell.
// Each cell holds its item while the next cell is full, so a stall on out
// fills bubbles first and only then drops in_ready.
// Reset clears all valid flags and loads the default breakpoint table.
// Configuration writes are always taken; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module battery_voltage_to_charge_percent_unit
    import bvcp_pkg::*;
#(
    parameter int POINT_COUNT = 10
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [MV_W-1:0]       battery_mv,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [CHG_W-1:0]      charge_percent,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [63:0] volt_0_3_reg;
    logic [63:0] volt_4_7_reg;
    logic [31:0] volt_8_9_reg;
    logic [63:0] pct_0_7_reg;
    logic [15:0] pct_8_9_reg;

    volt_tab_t volts;
    pct_tab_t  pcts;

    assign cfg_ready = 1'b1;

    // Write the breakpoint registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volt_0_3_reg <= VOLT_0_3_RST;
            volt_4_7_reg <= VOLT_4_7_RST;
            volt_8_9_reg <= VOLT_8_9_RST;
            pct_0_7_reg  <= PCT_0_7_RST;
            pct_8_9_reg  <= PCT_8_9_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_VOLT_0_3: volt_0_3_reg <= cfg_data;
                CFG_VOLT_4_7: volt_4_7_reg <= cfg_data;
                CFG_VOLT_8_9: volt_8_9_reg <= cfg_data[31:0];
                CFG_PCT_0_7:  pct_0_7_reg  <= cfg_data;
                CFG_PCT_8_9:  pct_8_9_reg  <= cfg_data[15:0];
                default:      ;
            endcase
        end
    end

    // Unpack the table, entry 0 in the low bits
    assign volts = {volt_8_9_reg, volt_4_7_reg, volt_0_3_reg};
    assign pcts  = {pct_8_9_reg, pct_0_7_reg};

    seg_data_t seg_data;
    logic      seg_valid;
    logic      seg_ready;

    div_data_t div_data  [QUO_W+1];
    logic      div_valid [QUO_W+1];
    logic      div_ready [QUO_W+1];

    bvcp_seg #(
        .POINT_COUNT (POINT_COUNT)
    ) u_seg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .battery_mv (battery_mv),
        .volts      (volts),
        .pcts       (pcts),
        .out_valid  (seg_valid),
        .out_ready  (seg_ready),
        .out_data   (seg_data)
    );

    bvcp_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (seg_valid),
        .in_ready  (seg_ready),
        .in_data   (seg_data),
        .out_valid (div_valid[0]),
        .out_ready (div_ready[0]),
        .out_data  (div_data[0])
    );

    // Divider row, most significant quotient bit first
    for (genvar k = 0; k < QUO_W; k++)
    begin : g_div
        bvcp_div_cell #(
            .BIT (QUO_W - 1 - k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_valid[k]),
            .in_ready  (div_ready[k]),
            .in_data   (div_data[k]),
            .out_valid (div_valid[k+1]),
            .out_ready (div_ready[k+1]),
            .out_data  (div_data[k+1])
        );
    end

    bvcp_finish u_finish (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (div_valid[QUO_W]),
        .in_ready       (div_ready[QUO_W]),
        .in_data        (div_data[QUO_W]),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .charge_percent (charge_percent)
    );

endmodule

### rtl/bvcp_checker.sv
// ----------------------------------------------------------------------------
// bvcp_checker
// Port-level checks for the charge percent unit, bound to the top level.
// ----------------------------------------------------------------------------
module bvcp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [12:0] battery_mv,
    input logic        out_valid,
    input logic        out_ready,
    input logic [6:0]  charge_percent,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(charge_percent))
        else $error("stalled result changed or dropped");

    // Never exceed full charge
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> charge_percent <= 7'd100)
        else $error("charge percent above 100");

    // Input stalls only behind a blocked output
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled with output free");

    // Configuration writes never wait
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

    // Hold an offered voltage until it is taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(battery_mv))
        else $error("offered voltage changed or dropped");

endmodule

bind battery_voltage_to_charge_percent_unit bvcp_checker u_bvcp_checker (.*);
